/* sv/fmtps_pkg.sv */
// Package: widths, codes and helper functions for the FM tuner PLL word serializer.
`default_nettype none
package fmtps_pkg;

   localparam int DIVIDER_BITS_DEF = 14;
   localparam int FREQ_W           = 17;
   localparam int IF_W             = 14;
   localparam int LEVEL_W          = 8;
   localparam int DIVIDEND_W       = FREQ_W + 1;
   localparam int DIVISOR_W        = 7;
   localparam int CSR_INDEX_W      = 3;
   localparam int CSR_DATA_W       = 17;
   localparam int BYTE_W           = 8;
   localparam int CMD_W            = 2;
   localparam int REFCODE_W        = 3;

   localparam logic [BYTE_W-1:0] BIT_DATA   = 8'h80;
   localparam logic [BYTE_W-1:0] BIT_CLOCK  = 8'h40;
   localparam logic [BYTE_W-1:0] BIT_ENABLE = 8'h02;

   localparam logic [LEVEL_W-1:0] REF_REQ_RESET = 8'd50;
   localparam logic [FREQ_W-1:0]  MIN_RESET     = 17'd87500;
   localparam logic [FREQ_W-1:0]  MAX_RESET     = 17'd108000;
   localparam logic [IF_W-1:0]    IF_RESET      = 14'd10700;

   typedef enum logic [CMD_W-1:0] {
      CMD_TUNE   = 2'd0,
      CMD_RETUNE = 2'd1,
      CMD_VOLUME = 2'd2
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REF_REQUEST = 3'd0,
      CSR_STEREO      = 3'd1,
      CSR_MUTE        = 3'd2,
      CSR_VOLUME      = 3'd3,
      CSR_MIN_FREQ    = 3'd4,
      CSR_MAX_FREQ    = 3'd5,
      CSR_IF_OFFSET   = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      STEP_25K  = 2'd0,
      STEP_50K  = 2'd1,
      STEP_100K = 2'd2
   } step_type;

   // one port write as seen by the output register
   typedef struct packed {
      logic [BYTE_W-1:0] port_byte;
      logic              last;
   } wr_type;

   function automatic step_type step_of(input logic [LEVEL_W-1:0] request);
      step_type s;
      if (request < 8'd38) begin
         s = STEP_25K;
      end else if (request < 8'd75) begin
         s = STEP_50K;
      end else begin
         s = STEP_100K;
      end
      return s;
   endfunction

   function automatic logic [DIVISOR_W-1:0] step_divisor(input step_type s);
      logic [DIVISOR_W-1:0] d;
      case (s)
         STEP_25K: d = 7'd25;
         STEP_50K: d = 7'd50;
         default:  d = 7'd100;
      endcase
      return d;
   endfunction

   // sent LSB first: 25 kHz -> 0,1,0; 50 kHz -> 0,0,1; 100 kHz -> 0,0,0
   function automatic logic [REFCODE_W-1:0] step_refcode(input step_type s);
      logic [REFCODE_W-1:0] c;
      case (s)
         STEP_25K: c = 3'b010;
         STEP_50K: c = 3'b100;
         default:  c = 3'b000;
      endcase
      return c;
   endfunction

   // volume code lands on port bits 0 and 2
   function automatic logic [BYTE_W-1:0] vol_byte(input logic mute,
                                                  input logic [LEVEL_W-1:0] level);
      logic [BYTE_W-1:0] v;
      if (mute || level < 8'd85) begin
         v = 8'h00;
      end else if (level < 8'd170) begin
         v = 8'h01;
      end else if (level < 8'd255) begin
         v = 8'h04;
      end else begin
         v = 8'h05;
      end
      return v;
   endfunction

endpackage
`default_nettype wire

/* sv/fmtps_if.sv */
// Interfaces: command channel and port-write channel.
`default_nettype none
interface fmtps_req_if;
   import fmtps_pkg::*;
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [FREQ_W-1:0]   frequency_khz;

   modport source (output valid, input ready, output command, output frequency_khz);
   modport sink   (input valid, output ready, input command, input frequency_khz);
endinterface

interface fmtps_rsp_if;
   import fmtps_pkg::*;
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   port_byte;
   logic                last;

   modport source (output valid, input ready, output port_byte, output last);
   modport sink   (input valid, output ready, input port_byte, input last);
endinterface
`default_nettype wire

/* sv/fmtps_divider.sv */
// Bit-serial restoring divider: one quotient bit per cycle by a small constant step.
`default_nettype none
module fmtps_divider #(
   parameter int QUOT_W = fmtps_pkg::DIVIDER_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [fmtps_pkg::DIVIDEND_W-1:0] dividend,
   input  wire logic [fmtps_pkg::DIVISOR_W-1:0]  divisor,
   output logic                                  done,
   output logic [QUOT_W-1:0]                     quotient
);
   import fmtps_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] num_ff, num_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  div_ff, div_in;
   logic [QUOT_W-1:0]     quot_ff, quot_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   assign trial = {rem_ff, num_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         quot_in = '0;
         cnt_in  = CNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         num_in  = {num_ff[DIVIDEND_W-2:0], 1'b0};
         // high quotient bits fall off the top: only the low bits are sent
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule
`default_nettype wire

/* sv/fmtps_serializer.sv */
// Word shifter: two port writes per word bit, LSB first, then a trailing write.
`default_nettype none
module fmtps_serializer #(
   parameter int WORD_W = fmtps_pkg::DIVIDER_BITS_DEF + 10
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         load,
   input  wire logic [WORD_W-1:0]            word,
   input  wire logic [fmtps_pkg::BYTE_W-1:0] vol,
   input  wire logic                         adv,
   output fmtps_pkg::wr_type                 wr,
   output logic                              active
);
   import fmtps_pkg::*;

   localparam int CNT_W = $clog2(WORD_W + 1);

   logic [WORD_W-1:0] word_ff, word_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              phase_ff, phase_in;
   logic              active_ff, active_in;
   logic              trailer;

   assign trailer = cnt_ff == CNT_W'(WORD_W);

   always_comb begin
      if (trailer) begin
         wr.port_byte = BIT_DATA | BIT_CLOCK | vol;
         wr.last      = 1'b1;
      end else begin
         wr.port_byte = (word_ff[0] ? BIT_DATA : '0) | BIT_ENABLE |
                        (phase_ff ? BIT_CLOCK : '0) | vol;
         wr.last      = 1'b0;
      end
   end

   always_comb begin
      word_in   = word_ff;
      cnt_in    = cnt_ff;
      phase_in  = phase_ff;
      active_in = active_ff;
      if (load) begin
         word_in   = word;
         cnt_in    = '0;
         phase_in  = 1'b0;
         active_in = 1'b1;
      end else if (adv && active_ff) begin
         if (trailer) begin
            active_in = 1'b0;
         end else if (phase_ff) begin
            // clock-high write done: advance to the next bit
            phase_in = 1'b0;
            word_in  = word_ff >> 1;
            cnt_in   = cnt_ff + 1'b1;
         end else begin
            phase_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      if (reset) begin
         cnt_ff    <= '0;
         phase_ff  <= 1'b0;
         active_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         phase_ff  <= phase_in;
         active_ff <= active_in;
      end
   end

   assign active = active_ff;

endmodule
`default_nettype wire

/* sv/fm_tuner_pll_word_serializer_core.sv */
// Top level: FM tuner PLL tuning-word serializer with command decode and settings.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-------------------------------
//  req     | in  | valid/ready   | command, frequency_khz
//  rsp     | out | valid/ready   | port_byte, last
//  csr     | in  | csr_wr_en     | csr_index, csr_wdata
//
// Tune/retune: accept, the bit-serial divider, a load into the shifter, then 49 port
// writes at one per cycle while rsp is ready. Volume refresh: 2 writes. Command 3 is
// dropped.
// Reset is synchronous; it restores the settings and the stored frequency.
// A stalled rsp holds the output register and pauses the shifter in place.
`default_nettype none
module fm_tuner_pll_word_serializer_core #(
   parameter int DIVIDER_BITS = fmtps_pkg::DIVIDER_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   fmtps_req_if.sink                              req,
   fmtps_rsp_if.source                            rsp,
   input  wire logic                              csr_wr_en,
   input  wire logic [fmtps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [fmtps_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import fmtps_pkg::*;

   localparam int WORD_W = DIVIDER_BITS + 10;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_SEND = 4'b0100,
      ST_MUTE = 4'b1000
   } state_type;

   // settings
   logic [LEVEL_W-1:0] ref_req_ff;
   logic               stereo_ff;
   logic               mute_ff;
   logic [LEVEL_W-1:0] level_ff;
   logic [FREQ_W-1:0]  min_ff;
   logic [FREQ_W-1:0]  max_ff;
   logic [IF_W-1:0]    if_ff;

   state_type          state_ff, state_in;
   logic [FREQ_W-1:0]  tuned_ff, tuned_in;
   step_type           step_ff, step_in;
   logic               word_stereo_ff, word_stereo_in;
   logic               mute_cnt_ff, mute_cnt_in;
   logic               out_valid_ff, out_valid_in;
   wr_type             out_ff, out_in;

   logic                    accept;
   logic                    take;
   logic [FREQ_W-1:0]       src;
   logic [FREQ_W-1:0]       capped;
   logic [FREQ_W-1:0]       clamped;
   logic [DIVIDEND_W-1:0]   dividend;
   logic [BYTE_W-1:0]       vol;
   logic                    div_start;
   logic                    div_done;
   logic [DIVIDER_BITS-1:0] quotient;
   logic [WORD_W-1:0]       word;
   logic                    ser_load;
   logic                    ser_adv;
   logic                    ser_active;
   wr_type                  ser_wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_req_ff <= REF_REQ_RESET;
         stereo_ff  <= 1'b1;
         mute_ff    <= 1'b0;
         level_ff   <= '0;
         min_ff     <= MIN_RESET;
         max_ff     <= MAX_RESET;
         if_ff      <= IF_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_REF_REQUEST: ref_req_ff <= csr_wdata[LEVEL_W-1:0];
            CSR_STEREO:      stereo_ff  <= csr_wdata[0];
            CSR_MUTE:        mute_ff    <= csr_wdata[0];
            CSR_VOLUME:      level_ff   <= csr_wdata[LEVEL_W-1:0];
            CSR_MIN_FREQ:    min_ff     <= csr_wdata[FREQ_W-1:0];
            CSR_MAX_FREQ:    max_ff     <= csr_wdata[FREQ_W-1:0];
            CSR_IF_OFFSET:   if_ff      <= csr_wdata[IF_W-1:0];
            default: ;
         endcase
      end
   end

   assign req.ready = state_ff == ST_IDLE;
   assign accept    = req.valid && req.ready;
   assign take      = !out_valid_ff || rsp.ready;
   assign vol       = vol_byte(mute_ff, level_ff);

   // ceiling first, floor second: floor wins when the limits cross
   assign src      = (req.command == CMD_RETUNE) ? tuned_ff : req.frequency_khz;
   assign capped   = (src > max_ff) ? max_ff : src;
   assign clamped  = (capped < min_ff) ? min_ff : capped;
   assign dividend = {1'b0, clamped} + {{(DIVIDEND_W - IF_W){1'b0}}, if_ff};

   assign word = {1'b1, step_refcode(step_ff), 2'b00, word_stereo_ff, 1'b1, 2'b00,
                  quotient};

   always_comb begin
      state_in       = state_ff;
      tuned_in       = tuned_ff;
      step_in        = step_ff;
      word_stereo_in = word_stereo_ff;
      mute_cnt_in    = mute_cnt_ff;
      out_valid_in   = out_valid_ff && !rsp.ready;
      out_in         = out_ff;
      div_start      = 1'b0;
      ser_load       = 1'b0;
      ser_adv        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req.command)
                  CMD_TUNE, CMD_RETUNE: begin
                     tuned_in       = clamped;
                     step_in        = step_of(ref_req_ff);
                     word_stereo_in = stereo_ff;
                     div_start      = 1'b1;
                     state_in       = ST_DIV;
                  end
                  CMD_VOLUME: begin
                     mute_cnt_in = 1'b0;
                     state_in    = ST_MUTE;
                  end
                  default: ;
               endcase
            end
         end
         ST_DIV: begin
            if (div_done) begin
               ser_load = 1'b1;
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (take && ser_active) begin
               out_valid_in = 1'b1;
               out_in       = ser_wr;
               ser_adv      = 1'b1;
               if (ser_wr.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_MUTE: begin
            if (take) begin
               out_valid_in     = 1'b1;
               out_in.port_byte = vol;
               out_in.last      = mute_cnt_ff;
               mute_cnt_in      = 1'b1;
               if (mute_cnt_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      step_ff        <= step_in;
      word_stereo_ff <= word_stereo_in;
      mute_cnt_ff    <= mute_cnt_in;
      out_ff         <= out_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         tuned_ff     <= MIN_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tuned_ff     <= tuned_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.port_byte = out_ff.port_byte;
   assign rsp.last      = out_ff.last;

   fmtps_divider #(
      .QUOT_W (DIVIDER_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (step_divisor(step_in)),
      .done     (div_done),
      .quotient (quotient)
   );

   fmtps_serializer #(
      .WORD_W (WORD_W)
   ) u_serializer (
      .clock  (clock),
      .reset  (reset),
      .load   (ser_load),
      .word   (word),
      .vol    (vol),
      .adv    (ser_adv),
      .wr     (ser_wr),
      .active (ser_active)
   );

endmodule
`default_nettype wire

/* sv/fmtps_checker.sv */
// Port checker for the serializer core and its bind to the top level.
`default_nettype none
module fmtps_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [1:0] req_command,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_port_byte,
   input wire logic       rsp_last
);
   import fmtps_pkg::*;

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_port_byte) && $stable(rsp_last))
      else $error("rsp word changed while stalled");

   // a real command keeps the block busy for at least the next cycle
   a_busy_after_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      (req_command == CMD_TUNE || req_command == CMD_RETUNE || req_command == CMD_VOLUME)
      |=> !req_ready)
      else $error("req accepted again right after a command");

   // the trailing write of a word raises clock and data with enable dropped
   a_trailer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last && rsp_port_byte[6] |-> rsp_port_byte[7] && !rsp_port_byte[1])
      else $error("bad trailing write");

   // unused port bits stay low
   a_unused_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_port_byte[5:3] == 3'b000)
      else $error("unused port bits set");

endmodule

bind fm_tuner_pll_word_serializer_core fmtps_checker u_fmtps_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .req_command   (req.command),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_port_byte (rsp.port_byte),
   .rsp_last      (rsp.last)
);
`default_nettype wire

/* dv/fmtps_word_checker.sv */
`timescale 1ns / 1ps
// Checker: predicts the PLL port writes from the command stream and compares them.
module fmtps_word_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   fmtps_req_if                                   req,
   fmtps_rsp_if                                   rsp,
   input  wire logic                              csr_wr_en,
   input  wire logic [fmtps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [fmtps_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                                     writes_due,
   output int                                     mismatches
);
   import fmtps_pkg::*;

   // shadow copy of the settings and the stored frequency
   logic [LEVEL_W-1:0] ref_request;
   logic               stereo_on;
   logic               mute_on;
   logic [LEVEL_W-1:0] level;
   logic [FREQ_W-1:0]  min_freq;
   logic [FREQ_W-1:0]  max_freq;
   logic [IF_W-1:0]    if_offset;
   logic [FREQ_W-1:0]  tuned_freq;

   wr_type port_writes_due[$];

   initial begin
      writes_due = 0;
      mismatches = 0;
   end

   task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                  input logic [BYTE_W-1:0] want);
      if (mismatches < 60) begin
         $display("%0t: mismatch, %s: got %02h, want %02h", $time, what, got, want);
      end
      mismatches++;
   endtask

   function automatic logic [BYTE_W-1:0] volume_bits();
      logic [BYTE_W-1:0] v;
      if (mute_on || level < 8'd85) begin
         v = 8'h00;
      end else if (level < 8'd170) begin
         v = 8'h01;
      end else if (level < 8'd255) begin
         v = 8'h04;
      end else begin
         v = 8'h05;
      end
      return v;
   endfunction

   task automatic push_write(input logic [BYTE_W-1:0] b, input logic is_last);
      wr_type w;
      w.port_byte = b;
      w.last      = is_last;
      port_writes_due.push_back(w);
   endtask

   task automatic predict_port_writes(input logic [CMD_W-1:0] cmd,
                                      input logic [FREQ_W-1:0] freq_in);
      logic [FREQ_W-1:0]    f;
      logic [BYTE_W-1:0]    vol;
      logic [BYTE_W-1:0]    d;
      logic [REFCODE_W-1:0] refcode;
      logic [23:0]          word;
      logic [31:0]          quotient;
      int unsigned          step;
      vol = volume_bits();
      if (cmd == CMD_VOLUME) begin
         push_write(vol, 1'b0);
         push_write(vol, 1'b1);
      end else if (cmd == CMD_TUNE || cmd == CMD_RETUNE) begin
         f = (cmd == CMD_TUNE) ? freq_in : tuned_freq;
         // ceiling first, floor second: floor wins when the limits cross
         if (f > max_freq) f = max_freq;
         if (f < min_freq) f = min_freq;
         tuned_freq = f;
         if (ref_request < 8'd38) begin
            step    = 25;
            refcode = 3'b010;
         end else if (ref_request < 8'd75) begin
            step    = 50;
            refcode = 3'b100;
         end else begin
            step    = 100;
            refcode = 3'b000;
         end
         quotient = (32'(f) + 32'(if_offset)) / step;
         word = {1'b1, refcode, 1'b0, 1'b0, stereo_on, 1'b1, 2'b00, quotient[13:0]};
         for (int i = 0; i < 24; i++) begin
            d = word[i] ? BIT_DATA : 8'h00;
            push_write(d | BIT_ENABLE | vol, 1'b0);
            push_write(d | BIT_CLOCK | BIT_ENABLE | vol, 1'b0);
         end
         push_write(BIT_DATA | BIT_CLOCK | vol, 1'b1);
      end
      // command 3 is dropped: nothing due, state untouched
   endtask

   always @(posedge clock) begin
      wr_type oldest;
      if (reset) begin
         ref_request = REF_REQ_RESET;
         stereo_on   = 1'b1;
         mute_on     = 1'b0;
         level       = '0;
         min_freq    = MIN_RESET;
         max_freq    = MAX_RESET;
         if_offset   = IF_RESET;
         tuned_freq  = MIN_RESET;
         port_writes_due.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (port_writes_due.size() == 0) begin
               report_mismatch("port write with nothing due", rsp.port_byte, 8'h00);
            end else begin
               oldest = port_writes_due.pop_front();
               if (rsp.port_byte !== oldest.port_byte) begin
                  report_mismatch("port_byte", rsp.port_byte, oldest.port_byte);
               end
               if (rsp.last !== oldest.last) begin
                  report_mismatch("last", 8'(rsp.last), 8'(oldest.last));
               end
            end
         end
         if (req.valid && req.ready) begin
            predict_port_writes(req.command, req.frequency_khz);
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_REF_REQUEST: ref_request = csr_wdata[LEVEL_W-1:0];
               CSR_STEREO:      stereo_on   = csr_wdata[0];
               CSR_MUTE:        mute_on     = csr_wdata[0];
               CSR_VOLUME:      level       = csr_wdata[LEVEL_W-1:0];
               CSR_MIN_FREQ:    min_freq    = csr_wdata[FREQ_W-1:0];
               CSR_MAX_FREQ:    max_freq    = csr_wdata[FREQ_W-1:0];
               CSR_IF_OFFSET:   if_offset   = csr_wdata[IF_W-1:0];
               default: ;
            endcase
         end
      end
      writes_due = port_writes_due.size();
   end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Testbench top: drives tune, retune and volume commands and settings, gives the verdict.
module testbench;
   import fmtps_pkg::*;

   // command code with no meaning: the block drops it
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     writes_due;
   int                     mismatches;

   int send_idle_pct;
   int recv_idle_pct;
   int rsp_hold_len;

   fmtps_req_if req_bus ();
   fmtps_rsp_if rsp_bus ();

   fm_tuner_pll_word_serializer_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   fmtps_word_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .rsp        (rsp_bus),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .writes_due (writes_due),
      .mismatches (mismatches)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // port side: random ready, or a long hold-off when asked for one
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_len != 0) begin
            hold_left    = rsp_hold_len;
            rsp_hold_len = 0;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [FREQ_W-1:0] freq);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.command       <= cmd;
      req_bus.frequency_khz <= freq;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // drop valid and hold until every due word has come out
   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (writes_due != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_setting(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_value(input int unsigned hi);
      int unsigned r;
      r = $urandom_range(0, 7);
      if (r == 0) return '0;
      if (r == 1) return CSR_DATA_W'(hi);
      return CSR_DATA_W'($urandom_range(0, hi));
   endfunction

   function automatic logic [LEVEL_W-1:0] pick_level(input logic is_volume);
      logic [LEVEL_W-1:0] ref_edges[6];
      logic [LEVEL_W-1:0] vol_edges[6];
      ref_edges = '{8'd0, 8'd37, 8'd38, 8'd74, 8'd75, 8'd255};
      vol_edges = '{8'd84, 8'd85, 8'd169, 8'd170, 8'd254, 8'd255};
      if ($urandom_range(0, 1)) return LEVEL_W'($urandom_range(0, 255));
      return is_volume ? vol_edges[$urandom_range(0, 5)] : ref_edges[$urandom_range(0, 5)];
   endfunction

   task automatic shuffle_settings();
      settle();
      if ($urandom_range(0, 1)) begin
         write_setting(CSR_REF_REQUEST, CSR_DATA_W'(pick_level(1'b0)));
      end
      if ($urandom_range(0, 1)) write_setting(CSR_STEREO, CSR_DATA_W'($urandom_range(0, 1)));
      if ($urandom_range(0, 2) == 0) begin
         write_setting(CSR_MUTE, CSR_DATA_W'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 1)) write_setting(CSR_VOLUME, CSR_DATA_W'(pick_level(1'b1)));
      if ($urandom_range(0, 2) == 0) begin
         write_setting(CSR_MIN_FREQ, $urandom_range(0, 3) == 0 ? pick_value(131071)
                                     : CSR_DATA_W'($urandom_range(0, 100000)));
      end
      if ($urandom_range(0, 2) == 0) begin
         write_setting(CSR_MAX_FREQ, $urandom_range(0, 3) == 0 ? pick_value(131071)
                                     : CSR_DATA_W'($urandom_range(80000, 131071)));
      end
      if ($urandom_range(0, 1)) write_setting(CSR_IF_OFFSET, pick_value(16383));
   endtask

   initial begin
      int                counted;
      int                block_left;
      int unsigned       r;
      logic [CMD_W-1:0]  cmd;
      logic [FREQ_W-1:0] freq;
      logic              held_off;
      logic              paused;

      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.command       = '0;
      req_bus.frequency_khz = '0;
      csr_wr_en             = 1'b0;
      csr_index             = '0;
      csr_wdata             = '0;
      send_idle_pct         = 17;
      recv_idle_pct         = 66;
      rsp_hold_len          = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // reset settings: retune straight away uses the reset frequency
      send_command(CMD_RETUNE, 17'h1ffff);
      send_command(CMD_TUNE, 17'd98000);
      send_command(CMD_TUNE, 17'd0);
      send_command(CMD_TUNE, 17'd131071);
      send_command(CMD_VOLUME, 17'd0);
      send_command(CMD_SPARE, 17'd55555);
      send_command(CMD_VOLUME, 17'h1ffff);

      // widest range, 25 kHz step, full offset
      settle();
      write_setting(CSR_REF_REQUEST, 17'd37);
      write_setting(CSR_STEREO, 17'd0);
      write_setting(CSR_VOLUME, 17'd255);
      write_setting(CSR_MIN_FREQ, 17'd0);
      write_setting(CSR_MAX_FREQ, 17'd131071);
      write_setting(CSR_IF_OFFSET, 17'd16383);
      send_command(CMD_TUNE, 17'd131071);
      send_command(CMD_TUNE, 17'd0);
      send_command(CMD_VOLUME, 17'd0);

      settle();
      write_setting(CSR_IF_OFFSET, 17'd0);
      write_setting(CSR_REF_REQUEST, 17'd38);
      write_setting(CSR_VOLUME, 17'd170);
      send_command(CMD_TUNE, 17'd0);
      send_command(CMD_TUNE, 17'd100000);
      send_command(CMD_VOLUME, 17'd0);

      settle();
      write_setting(CSR_VOLUME, 17'd169);
      write_setting(CSR_REF_REQUEST, 17'd74);
      send_command(CMD_VOLUME, 17'd0);
      send_command(CMD_TUNE, 17'd131071);

      settle();
      write_setting(CSR_MUTE, 17'd1);
      write_setting(CSR_REF_REQUEST, 17'd75);
      write_setting(CSR_VOLUME, 17'd85);
      send_command(CMD_VOLUME, 17'd0);
      send_command(CMD_TUNE, 17'd90000);

      // crossed limits: the floor wins, retune reclamps the stored value
      settle();
      write_setting(CSR_MUTE, 17'd0);
      write_setting(CSR_VOLUME, 17'd84);
      write_setting(CSR_REF_REQUEST, 17'd255);
      write_setting(CSR_MIN_FREQ, 17'd100000);
      write_setting(CSR_MAX_FREQ, 17'd90000);
      send_command(CMD_TUNE, 17'd95000);
      send_command(CMD_RETUNE, 17'd0);
      send_command(CMD_VOLUME, 17'd0);

      settle();
      write_setting(CSR_VOLUME, 17'd254);
      send_command(CMD_VOLUME, 17'd0);

      counted    = 0;
      block_left = 0;
      held_off   = 1'b0;
      paused     = 1'b0;
      while (counted < 300) begin
         if (counted < 100) begin
            send_idle_pct = 17;
            recv_idle_pct = 66;
         end else if (counted < 200) begin
            send_idle_pct = 66;
            recv_idle_pct = 17;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (block_left == 0) begin
            shuffle_settings();
            block_left = $urandom_range(10, 30);
         end
         if (counted == 150 && !held_off) begin
            rsp_hold_len = 600;
            held_off     = 1'b1;
         end
         if (counted == 250 && !paused) begin
            settle();
            paused = 1'b1;
         end
         r = $urandom_range(0, 19);
         if (r < 11) cmd = CMD_TUNE;
         else if (r < 14) cmd = CMD_RETUNE;
         else if (r < 18) cmd = CMD_VOLUME;
         else cmd = CMD_SPARE;
         r = $urandom_range(0, 7);
         if (r == 0) freq = '0;
         else if (r == 1) freq = 17'd131071;
         else if (r < 5) freq = FREQ_W'($urandom_range(0, 131071));
         else freq = FREQ_W'($urandom_range(85000, 110000));
         send_command(cmd, freq);
         counted++;
         block_left--;
      end

      settle();
      repeat (100) @(posedge clock);
      if (mismatches == 0 && writes_due == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
